// ===== rtl/core/zcpe_pkg.sv =====
// Shared types and constants for the zone crossing period estimator.
package zcpe_pkg;

    localparam int unsigned CfgWidth    = 16;
    localparam int unsigned OffsetWidth = 16;
    localparam int unsigned PeriodWidth = 16;
    localparam int unsigned CountWidth  = 2;
    localparam int unsigned NowWidth    = 32;
    localparam int unsigned SumWidth    = PeriodWidth + 2;

    localparam logic [CountWidth-1:0] HistDepth = CountWidth'(3);
    localparam logic [CountWidth-1:0] MinForAvg = CountWidth'(2);

    // x / 3 == (x * ceil(2^19 / 3)) >> 19, exact for every 18-bit x
    localparam int unsigned Div3Shift = 19;
    localparam logic [SumWidth-1:0] Div3Mult = SumWidth'(174763);

    typedef enum logic [1:0] {
        CFG_ENTER_THRESHOLD = 2'd0,
        CFG_EXIT_THRESHOLD  = 2'd1,
        CFG_MIN_PERIOD      = 2'd2,
        CFG_MAX_PERIOD      = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_FRAME   = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic rising;
    } t_hist_ctl;

    typedef struct packed {
        logic [CountWidth-1:0]  held;
        logic [PeriodWidth-1:0] p0;
        logic [PeriodWidth-1:0] p1;
        logic [PeriodWidth-1:0] p2;
    } t_hist;

endpackage

// ===== rtl/core/zcpe_zone.sv =====
// Hysteresis zone flag and rising edge detect.
module zcpe_zone
    import zcpe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_cmd,
    input  logic                   i_enough_samples,
    input  logic [OffsetWidth-1:0] i_pixel_offset,
    input  logic [CfgWidth-1:0]    i_enter_threshold,
    input  logic [CfgWidth-1:0]    i_exit_threshold,
    output logic                   o_zone_next,
    output t_hist_ctl              o_ctl
);

    logic r_zone;
    logic n_zone;
    logic now_in;
    logic is_restart;

    assign is_restart = (t_cmd'(i_cmd) == CMD_RESTART);
    assign now_in     = i_pixel_offset < i_enter_threshold;

    always_comb begin
        n_zone = r_zone;
        if (is_restart) begin
            n_zone = 1'b0;
        end else if (i_enough_samples) begin
            // enter test wins when the thresholds cross
            if (now_in) begin
                n_zone = 1'b1;
            end else if (i_pixel_offset > i_exit_threshold) begin
                n_zone = 1'b0;
            end
        end
    end

    assign o_ctl.restart = is_restart;
    assign o_ctl.rising  = !is_restart && i_enough_samples && now_in && !r_zone;
    assign o_zone_next   = n_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= 1'b0;
        end else if (i_fire) begin
            r_zone <= n_zone;
        end
    end

endmodule

// ===== rtl/core/zcpe_hist.sv =====
// Entry timestamp, period window check and three-deep period history.
module zcpe_hist
    import zcpe_pkg::*;
#(
    parameter int unsigned TIMESTAMP_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  t_hist_ctl                 i_ctl,
    input  logic [TIMESTAMP_BITS-1:0] i_now,
    input  logic [CfgWidth-1:0]       i_min_period,
    input  logic [CfgWidth-1:0]       i_max_period,
    output t_hist                     o_hist_next
);

    logic                      r_have_last;
    logic [TIMESTAMP_BITS-1:0] r_last;
    t_hist                     r_hist;

    logic                      n_have_last;
    logic [TIMESTAMP_BITS-1:0] n_last;
    t_hist                     n_hist;

    logic [TIMESTAMP_BITS-1:0] period;
    logic                      in_window;

    // wraps modulo 2^TIMESTAMP_BITS
    assign period    = i_now - r_last;
    assign in_window = (period >= TIMESTAMP_BITS'(i_min_period)) &&
                       (period <= TIMESTAMP_BITS'(i_max_period));

    always_comb begin
        n_have_last = r_have_last;
        n_last      = r_last;
        n_hist      = r_hist;
        if (i_ctl.restart) begin
            n_have_last = 1'b0;
            n_hist.held = '0;
        end else if (i_ctl.rising) begin
            if (r_have_last) begin
                if (in_window) begin
                    n_hist.p2 = r_hist.p1;
                    n_hist.p1 = r_hist.p0;
                    n_hist.p0 = period[PeriodWidth-1:0];
                    if (r_hist.held != HistDepth) begin
                        n_hist.held = r_hist.held + CountWidth'(1);
                    end
                end else begin
                    n_hist.held = '0;
                end
            end
            n_last      = i_now;
            n_have_last = 1'b1;
        end
    end

    assign o_hist_next = n_hist;

    // entries above the held count are never read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
            r_last      <= '0;
            r_hist      <= '0;
        end else if (i_fire) begin
            r_have_last <= n_have_last;
            r_last      <= n_last;
            r_hist      <= n_hist;
        end
    end

endmodule

// ===== rtl/core/zcpe_avg.sv =====
// Truncated mean of 2-3 held periods, else zero; divide by 3 via reciprocal multiply.
module zcpe_avg
    import zcpe_pkg::*;
(
    input  t_hist                  i_hist,
    output logic                   o_valid,
    output logic [PeriodWidth-1:0] o_avg
);

    logic [SumWidth-1:0]   sum;
    logic [2*SumWidth-1:0] prod;

    always_comb begin
        sum = SumWidth'(i_hist.p0) + SumWidth'(i_hist.p1);
        if (i_hist.held == HistDepth) begin
            sum = sum + SumWidth'(i_hist.p2);
        end
    end

    assign prod    = sum * Div3Mult;
    assign o_valid = (i_hist.held >= MinForAvg);

    always_comb begin
        o_avg = '0;
        if (i_hist.held == HistDepth) begin
            o_avg = prod[Div3Shift +: PeriodWidth];
        end else if (i_hist.held == MinForAvg) begin
            o_avg = sum[PeriodWidth:1];
        end
    end

endmodule

// ===== rtl/core/zone_crossing_period_estimator_core.sv =====
// Top level of the zone crossing period estimator: input stage, tracking logic, result stage.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+----------------------------------------
//  in      | in        | i_in_valid / o_in_stall      | i_cmd i_enough_samples i_pixel_offset
//          |           |                              | i_now_ms
//  out     | out       | o_out_valid / i_out_stall    | o_in_zone o_zone_entry o_period_valid
//          |           |                              | o_avg_period_ms o_period_count
//  cfg     | in        | i_cfg_we (no wait)           | i_cfg_index i_cfg_wdata
//
// One beat per cycle sustained while the result is not stalled; a result passes through the input
// register, then tracking logic into the result register.
// Tracking state updates when a beat moves from the input register to the result register.
// Reset (synchronous, active low) empties both stages, clears tracking, loads default thresholds.
// A stalled result holds the result register; the input register then fills and o_in_stall rises.
module zone_crossing_period_estimator_core
    import zcpe_pkg::*;
#(
    parameter int unsigned TIMESTAMP_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_cmd,
    input  logic                   i_enough_samples,
    input  logic [OffsetWidth-1:0] i_pixel_offset,
    input  logic [NowWidth-1:0]    i_now_ms,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_in_zone,
    output logic                   o_zone_entry,
    output logic                   o_period_valid,
    output logic [PeriodWidth-1:0] o_avg_period_ms,
    output logic [CountWidth-1:0]  o_period_count,

    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [CfgWidth-1:0]    i_cfg_wdata
);

    localparam int unsigned ExtWidth = (TIMESTAMP_BITS > NowWidth) ? TIMESTAMP_BITS : NowWidth;

    // configuration
    logic [CfgWidth-1:0] r_enter_threshold;
    logic [CfgWidth-1:0] r_exit_threshold;
    logic [CfgWidth-1:0] r_min_period;
    logic [CfgWidth-1:0] r_max_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_threshold <= CfgWidth'(160);
            r_exit_threshold  <= CfgWidth'(320);
            r_min_period      <= CfgWidth'(100);
            r_max_period      <= CfgWidth'(2000);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENTER_THRESHOLD: r_enter_threshold <= i_cfg_wdata;
                CFG_EXIT_THRESHOLD:  r_exit_threshold  <= i_cfg_wdata;
                CFG_MIN_PERIOD:      r_min_period      <= i_cfg_wdata;
                CFG_MAX_PERIOD:      r_max_period      <= i_cfg_wdata;
            endcase
        end
    end

    // input stage
    logic                   r_in_valid;
    logic                   r_cmd;
    logic                   r_enough;
    logic [OffsetWidth-1:0] r_offset;
    logic [NowWidth-1:0]    r_now;

    logic advance;
    logic fire;
    logic in_take;

    assign advance    = !o_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd    <= i_cmd;
            r_enough <= i_enough_samples;
            r_offset <= i_pixel_offset;
            r_now    <= i_now_ms;
        end
    end

    // tracking
    logic                      zone_next;
    t_hist_ctl                 ctl;
    t_hist                     hist_next;
    logic [ExtWidth-1:0]       now_ext;
    logic [TIMESTAMP_BITS-1:0] now_ts;
    logic                      avg_valid;
    logic [PeriodWidth-1:0]    avg;

    assign now_ext = ExtWidth'(r_now);
    assign now_ts  = now_ext[TIMESTAMP_BITS-1:0];

    zcpe_zone u_zone (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_cmd             (r_cmd),
        .i_enough_samples  (r_enough),
        .i_pixel_offset    (r_offset),
        .i_enter_threshold (r_enter_threshold),
        .i_exit_threshold  (r_exit_threshold),
        .o_zone_next       (zone_next),
        .o_ctl             (ctl)
    );

    zcpe_hist #(
        .TIMESTAMP_BITS (TIMESTAMP_BITS)
    ) u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_ctl        (ctl),
        .i_now        (now_ts),
        .i_min_period (r_min_period),
        .i_max_period (r_max_period),
        .o_hist_next  (hist_next)
    );

    zcpe_avg u_avg (
        .i_hist  (hist_next),
        .o_valid (avg_valid),
        .o_avg   (avg)
    );

    // result stage
    logic                   r_out_valid;
    logic                   r_in_zone;
    logic                   r_zone_entry;
    logic                   r_period_valid;
    logic [PeriodWidth-1:0] r_avg;
    logic [CountWidth-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_in_zone      <= zone_next;
            r_zone_entry   <= ctl.rising;
            r_period_valid <= avg_valid;
            r_avg          <= avg;
            r_count        <= hist_next.held;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_in_zone       = r_in_zone;
    assign o_zone_entry    = r_zone_entry;
    assign o_period_valid  = r_period_valid;
    assign o_avg_period_ms = r_avg;
    assign o_period_count  = r_count;

endmodule

// ===== rtl/core/zcpe_checker.sv =====
// Port-level checks for the zone crossing period estimator and the bind that attaches them.
module zcpe_checker
    import zcpe_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic                   o_in_zone,
    input logic                   o_zone_entry,
    input logic                   o_period_valid,
    input logic [PeriodWidth-1:0] o_avg_period_ms,
    input logic [CountWidth-1:0]  o_period_count
);

    // average is reported exactly when two or more periods are held
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_period_valid == ((o_period_count == MinForAvg) ||
                                            (o_period_count == HistDepth))))
        else $error("period_valid disagrees with period_count");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_period_valid) |-> (o_avg_period_ms == '0))
        else $error("average nonzero while invalid");

    a_rise_in_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zone_entry) |-> o_in_zone)
        else $error("zone entry reported outside the zone");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_avg_period_ms) &&
                                          $stable(o_period_count) && $stable(o_in_zone)))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

endmodule

bind zone_crossing_period_estimator_core zcpe_checker u_zcpe_checker (.*);
